FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the MD5 digest block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/md5ds_pkg.sv
// Package with types, constants and helper functions of the MD5 digest block.
`timescale 1ns / 1ps
`default_nettype none
package md5ds_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [3:0][31:0] quad_t;

  localparam int BLOCK_WORDS = 16;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Initial chaining values; index 0 is A.
  localparam quad_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam word_t ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] SHIFT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } round_ctl_t;

  // Message word used by round r.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] g;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'(lo * 4'd5 + 4'd1);
      2'd2:    g = 4'(lo * 4'd3 + 4'd5);
      default: g = 4'(lo * 4'd7);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/md5ds_if.sv
// Handshake interfaces of the message input and the digest output channels.
`timescale 1ns / 1ps
`default_nettype none
interface md5ds_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source(output valid, message_word, byte_count, last_word, input ready);
  modport sink(input valid, message_word, byte_count, last_word, output ready);
endinterface

interface md5ds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        final_word;

  modport source(output valid, digest_word, word_index, final_word, input ready);
  modport sink(input valid, digest_word, word_index, final_word, output ready);
endinterface
`default_nettype wire

FILE: hdl/md5ds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module md5ds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hdl/md5ds_round.sv
// MD5 round unit: working registers, round counter and one round per cycle while stepping.
`timescale 1ns / 1ps
`default_nettype none
module md5ds_round (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire md5ds_pkg::round_ctl_t  ctl,
  input  wire md5ds_pkg::quad_t       chain_in,
  input  wire md5ds_pkg::word_t       msg_word,
  output      md5ds_pkg::quad_t       regs,
  output      logic [5:0]             round_idx
);
  import md5ds_pkg::*;

  quad_t      regs_r;
  quad_t      regs_nxt;
  logic [5:0] idx_r;
  logic [5:0] idx_nxt;
  word_t      f;
  word_t      sum;
  logic [4:0] shamt;
  logic [63:0] rot_wide;

  always_comb begin
    unique case (idx_r[5:4])
      2'd0:    f = (regs_r[1] & regs_r[2]) | (~regs_r[1] & regs_r[3]);
      2'd1:    f = (regs_r[1] & regs_r[3]) | (regs_r[2] & ~regs_r[3]);
      2'd2:    f = regs_r[1] ^ regs_r[2] ^ regs_r[3];
      default: f = regs_r[2] ^ (regs_r[1] | ~regs_r[3]);
    endcase
    sum      = regs_r[0] + f + ROUND_K[idx_r] + msg_word;
    shamt    = SHIFT_AMT[{idx_r[5:4], idx_r[1:0]}];
    rot_wide = {sum, sum} << shamt;

    regs_nxt = regs_r;
    idx_nxt  = idx_r;
    if (ctl.load) begin
      regs_nxt = chain_in;
      idx_nxt  = '0;
    end else if (ctl.step) begin
      regs_nxt[0] = regs_r[3];
      regs_nxt[3] = regs_r[2];
      regs_nxt[2] = regs_r[1];
      regs_nxt[1] = regs_r[1] + rot_wide[63:32];
      idx_nxt     = idx_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
      idx_r  <= '0;
    end else begin
      regs_r <= regs_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign regs      = regs_r;
  assign round_idx = idx_r;

endmodule
`default_nettype wire

FILE: hdl/md5ds_out_buf.sv
// Output buffer that holds a finished digest and sends its four words in order.
`timescale 1ns / 1ps
`default_nettype none
module md5ds_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire md5ds_pkg::quad_t words,
  output      logic             busy,
  md5ds_out_if.source           out_dig
);
  import md5ds_pkg::*;

  quad_t      buf_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       xfer;

  assign xfer = out_dig.valid && out_dig.ready;

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= words;
    end
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else if (load) begin
      idx_r  <= '0;
      busy_r <= 1'b1;
    end else if (xfer) begin
      idx_r <= idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy                = busy_r;
  assign out_dig.valid       = busy_r;
  assign out_dig.digest_word = buf_r[idx_r];
  assign out_dig.word_index  = idx_r;
  assign out_dig.final_word  = (idx_r == 2'd3);

endmodule
`default_nettype wire

FILE: hdl/md5_digest_stream.sv
// Flow: a word that is not the last and leaves its block open is taken with the input kept
// ready; a word that fills a block holds the input off through the load, the rounds and the
// chaining add of the round unit, which reads the block memory, so no new word is taken
// until that block is compressed. A last word adds padding words plus one or two compressions.
// Reset (synchronous, active low) restores the chaining words and clears the counters;
// the block memory is not cleared, since every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module md5_digest_stream (
  input  wire logic   clk,
  input  wire logic   rst_n,
  md5ds_in_if.sink    in_msg,
  md5ds_out_if.source out_dig
);
  import md5ds_pkg::*;

  // Control and bookkeeping registers. The sixteen message words of the block
  // being gathered live in the block memory, addressed by the fill index.
  state_t      state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] total_r, total_nxt;
  quad_t       chain_r, chain_nxt;
  logic        final_r, final_nxt;       // message closed, padding under way
  logic        pad_pend_r, pad_pend_nxt; // 0x80 word still to be pushed
  logic        len_lo_r, len_lo_nxt;     // low length word pushed
  logic        len_hi_r, len_hi_nxt;     // high length word pushed

  logic        in_xfer;
  logic [2:0]  cnt_sat;
  word_t       tail_word;
  logic [63:0] bit_len;

  logic        ram_we;
  word_t       ram_wdata;
  logic [3:0]  ram_raddr;
  word_t       ram_rdata;

  round_ctl_t  rctl;
  quad_t       round_regs;
  logic [5:0]  round_idx;

  logic        out_load;
  logic        out_busy;

  assign in_xfer      = in_msg.valid && in_msg.ready;
  assign in_msg.ready = (state_r == ST_IDLE);

  // A byte count beyond four on the last word counts as a full word.
  assign cnt_sat = (in_msg.byte_count > 3'd4) ? 3'd4 : in_msg.byte_count;
  assign bit_len = {total_r[60:0], 3'b000};

  // Partial last word: keep the valid bytes, place the pad byte right after them.
  always_comb begin
    unique case (cnt_sat)
      3'd0:    tail_word = {24'h000000, PAD_BYTE};
      3'd1:    tail_word = {16'h0000, PAD_BYTE, in_msg.message_word[7:0]};
      3'd2:    tail_word = {8'h00, PAD_BYTE, in_msg.message_word[15:0]};
      3'd3:    tail_word = {PAD_BYTE, in_msg.message_word[23:0]};
      default: tail_word = in_msg.message_word;
    endcase
  end

  // Sequencer: gather words, pad, compress, hand the digest to the output buffer.
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    total_nxt    = total_r;
    chain_nxt    = chain_r;
    final_nxt    = final_r;
    pad_pend_nxt = pad_pend_r;
    len_lo_nxt   = len_lo_r;
    len_hi_nxt   = len_hi_r;
    ram_we       = 1'b0;
    ram_wdata    = in_msg.message_word;
    ram_raddr    = '0;
    rctl         = '0;
    out_load     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ram_we   = 1'b1;
          fill_nxt = fill_r + 4'd1;
          if (in_msg.last_word) begin
            ram_wdata    = tail_word;
            total_nxt    = total_r + 64'(cnt_sat);
            final_nxt    = 1'b1;
            pad_pend_nxt = (cnt_sat == 3'd4);
          end else begin
            total_nxt = total_r + 64'd4;
          end
          if (fill_r == 4'd15) begin
            state_nxt = ST_LOAD;
          end else if (in_msg.last_word) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // One padding word per cycle: the pad byte after a full last word, then zero fill
        // up to entry 14 of the last block, then the bit length, low word first.
        ram_we   = 1'b1;
        fill_nxt = fill_r + 4'd1;
        priority if (pad_pend_r) begin
          ram_wdata    = {24'h000000, PAD_BYTE};
          pad_pend_nxt = 1'b0;
        end else if (fill_r == 4'd14 && !len_lo_r) begin
          ram_wdata  = bit_len[31:0];
          len_lo_nxt = 1'b1;
        end else if (fill_r == 4'd15 && len_lo_r) begin
          ram_wdata  = bit_len[63:32];
          len_hi_nxt = 1'b1;
        end else begin
          ram_wdata = '0;
        end
        if (fill_r == 4'd15) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Copy the chaining words in and fetch the first round's message word.
        rctl.load = 1'b1;
        ram_raddr = msg_index(6'd0);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        // The memory read for the following round is issued during the current round.
        rctl.step = 1'b1;
        ram_raddr = msg_index(round_idx + 6'd1);
        if (round_idx == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + round_regs[i];
        end
        if (len_hi_r) begin
          state_nxt = ST_DONE;
        end else if (final_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        // Waits only while the previous digest is still being transferred.
        if (!out_busy) begin
          out_load     = 1'b1;
          chain_nxt    = CHAIN_INIT;
          total_nxt    = '0;
          final_nxt    = 1'b0;
          pad_pend_nxt = 1'b0;
          len_lo_nxt   = 1'b0;
          len_hi_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      total_r    <= '0;
      chain_r    <= CHAIN_INIT;
      final_r    <= 1'b0;
      pad_pend_r <= 1'b0;
      len_lo_r   <= 1'b0;
      len_hi_r   <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      total_r    <= total_nxt;
      chain_r    <= chain_nxt;
      final_r    <= final_nxt;
      pad_pend_r <= pad_pend_nxt;
      len_lo_r   <= len_lo_nxt;
      len_hi_r   <= len_hi_nxt;
    end
  end

  // Block memory: written while gathering or padding; its read data is used only while
  // compressing, when no write is made, so each round reads a settled entry.
  md5ds_ram #(
    .WIDTH(32),
    .DEPTH(BLOCK_WORDS)
  ) u_block_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  md5ds_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rctl),
    .chain_in (chain_r),
    .msg_word (ram_rdata),
    .regs     (round_regs),
    .round_idx(round_idx)
  );

  // The finished digest moves to its own buffer, so a new message can be taken
  // while the four digest words are still being transferred.
  md5ds_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .words  (chain_r),
    .busy   (out_busy),
    .out_dig(out_dig)
  );

  `ASSERT_NEXT(a_rounds_end, clk, rst_n, state_r == ST_ROUND && round_idx == 6'd63, state_r == ST_ADD)
  `ASSERT_IMPLIES(a_block_full, clk, rst_n, state_r == ST_LOAD, fill_r == 4'd0 && round_idx == 6'd0)
  `ASSERT_IMPLIES(a_no_write_compress, clk, rst_n, state_r == ST_LOAD || state_r == ST_ROUND || state_r == ST_ADD, !ram_we)
  `ASSERT_NEXT(a_digest_start, clk, rst_n, state_r == ST_DONE && !out_busy, out_dig.valid && out_dig.word_index == 2'd0)

endmodule
`default_nettype wire
